// File: src/upbt_pkg.sv
// ----------------------------------------------------------------------------
// upbt_pkg: shared types and constants for the UDP port binding table
// Word formats, function and status codes, table sizing, controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package upbt_pkg;

    // Table sizing
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Tries counter must hold ENTRIES + 1
    localparam int TRY_W   = $clog2(ENTRIES + 2);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPH_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPH_MAX = 1'd1;
    localparam logic [15:0] EPH_MIN_RESET = 16'd49152;
    localparam logic [15:0] EPH_MAX_RESET = 16'd65535;

    // Function codes
    localparam logic [2:0] FUNC_OPEN   = 3'd0;
    localparam logic [2:0] FUNC_CLOSE  = 3'd1;
    localparam logic [2:0] FUNC_BIND   = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_SRCSEL = 3'd4;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_NOT_OPEN = 3'd2;
    localparam logic [2:0] STS_BOUND    = 3'd3;
    localparam logic [2:0] STS_NO_PORT  = 3'd4;
    localparam logic [2:0] STS_NO_MATCH = 3'd5;

    // Request word
    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  entry_id;
        logic [31:0] endpoint_addr;
        logic [15:0] endpoint_port;
        logic [31:0] route_addr;
    } req_t;

    // Response word
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_id;
        logic [31:0] local_addr;
        logic [15:0] local_port;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic commit;
        logic step;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_search;
        logic search_hit;
        logic search_end;
        logic out_free;
    } dp_stat_t;

endpackage

// File: src/udp_port_binding_table.sv
// ----------------------------------------------------------------------------
// udp_port_binding_table: socket entry table with ephemeral port assignment
// Open, close, bind, lookup and source select over a table of local
// endpoints, with automatic source port selection from a configured range.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, word req) carries one operation; rsp
//   channel (rsp_valid/rsp_ready, word rsp) returns one response word for
//   each request, in order. cfg_we/cfg_index/cfg_data write the ephemeral
//   port range (index 0 lowest, index 1 highest port); write only while idle.
//   Sequence: the request is captured at the accepting edge and executed in
//   the next cycle. Open, close, bind, lookup and source select of a bound
//   entry commit from the execute state once the response register is free,
//   and the response is registered. A source select on an entry with port 0
//   goes to the search state, which tries one candidate port per cycle until
//   a decision, through the single compare bank that checks a candidate
//   against all entries: up to ENTRIES + 1 candidates are tried.
//   One request is in execution at a time; the next is accepted the cycle
//   after the previous one has committed, even while its response still
//   waits.
//   Reset: all entries free with address and port zero, range 49152..65535,
//   no response pending. If the receiver stalls, the response register holds
//   its word and a finished operation waits before commit until it is free.
// ----------------------------------------------------------------------------
module udp_port_binding_table
    import upbt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    upbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, compare bank and response register
    upbt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: src/upbt_dp.sv
// ----------------------------------------------------------------------------
// upbt_dp: datapath of the UDP port binding table
// Entry table, parallel endpoint compare, ephemeral port candidate counter,
// configuration registers and the response register.
// ----------------------------------------------------------------------------
module upbt_dp
    import upbt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    output rsp_t                 rsp,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat
);

    // Table and working registers
    logic [ENTRIES-1:0] open_reg, open_next;
    logic [31:0]        addr_reg [ENTRIES];
    logic [31:0]        addr_next [ENTRIES];
    logic [15:0]        port_reg [ENTRIES];
    logic [15:0]        port_next [ENTRIES];
    req_t               req_reg;
    logic [16:0]        cand_reg;
    logic [TRY_W-1:0]   tries_reg;
    logic [15:0]        eph_min_reg, eph_max_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]   idx;
    logic               id_ok, entry_ok;
    logic [31:0]        sel_addr;
    logic [31:0]        key_addr;
    logic [15:0]        key_port;
    logic [ENTRIES-1:0] match_vec;
    logic               any_match, any_free;
    logic [IDX_W-1:0]   match_idx, free_idx;
    logic               in_range;

    // Addressed entry and its state
    assign idx      = IDX_W'(req_reg.entry_id);
    assign id_ok    = 32'(req_reg.entry_id) < ENTRIES;
    assign entry_ok = id_ok && open_reg[idx];
    assign sel_addr = (addr_reg[idx] != 32'd0) ? addr_reg[idx] : req_reg.route_addr;

    assign stat.need_search = (req_reg.func == FUNC_SRCSEL) && entry_ok
                              && (port_reg[idx] == 16'd0);

    // Compare key: endpoint for bind and lookup, candidate for port search
    assign key_addr = stat.need_search ? sel_addr : req_reg.endpoint_addr;
    assign key_port = stat.need_search ? cand_reg[15:0] : req_reg.endpoint_port;

    // Parallel compare against every entry
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = open_reg[i] && (port_reg[i] == key_port)
                           && ((addr_reg[i] == 32'd0) || (key_addr == 32'd0)
                               || (addr_reg[i] == key_addr));
        end
    end

    // Lowest matching entry and lowest free entry
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (!open_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |match_vec;
    assign any_free  = ~&open_reg;

    // Candidate port search state
    assign in_range = (cand_reg <= {1'b0, eph_max_reg})
                      && (32'(tries_reg) < ENTRIES + 1);
    assign stat.search_hit = in_range && (cand_reg[15:0] != 16'd0) && !any_match;
    assign stat.search_end = !in_range;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    // Table update and response on commit
    always_comb
    begin
        open_next      = open_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            unique case (req_reg.func)
                FUNC_OPEN:
                begin
                    if (any_free)
                    begin
                        open_next[free_idx] = 1'b1;
                        rsp_next.result_id  = 4'(free_idx);
                    end
                    else
                    begin
                        rsp_next.status = STS_FULL;
                    end
                end
                FUNC_CLOSE:
                begin
                    if (!entry_ok)
                    begin
                        rsp_next.status = STS_NOT_OPEN;
                    end
                    else
                    begin
                        open_next[idx] = 1'b0;
                        addr_next[idx] = '0;
                        port_next[idx] = '0;
                    end
                end
                FUNC_BIND:
                begin
                    if (!entry_ok)
                    begin
                        rsp_next.status = STS_NOT_OPEN;
                    end
                    else if (any_match)
                    begin
                        rsp_next.status = STS_BOUND;
                    end
                    else
                    begin
                        addr_next[idx] = req_reg.endpoint_addr;
                        port_next[idx] = req_reg.endpoint_port;
                    end
                end
                FUNC_LOOKUP:
                begin
                    if (any_match)
                    begin
                        rsp_next.result_id = 4'(match_idx);
                    end
                    else
                    begin
                        rsp_next.status = STS_NO_MATCH;
                    end
                end
                FUNC_SRCSEL:
                begin
                    if (!entry_ok)
                    begin
                        rsp_next.status = STS_NOT_OPEN;
                    end
                    else if (!stat.need_search)
                    begin
                        rsp_next.local_addr = sel_addr;
                        rsp_next.local_port = port_reg[idx];
                    end
                    else if (stat.search_hit)
                    begin
                        port_next[idx]      = cand_reg[15:0];
                        rsp_next.local_addr = sel_addr;
                        rsp_next.local_port = cand_reg[15:0];
                    end
                    else
                    begin
                        rsp_next.status = STS_NO_PORT;
                    end
                end
                default:
                begin
                    rsp_next.status = STS_NO_MATCH;
                end
            endcase
        end
    end

    // Control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            eph_min_reg   <= EPH_MIN_RESET;
            eph_max_reg   <= EPH_MAX_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                addr_reg[i] <= '0;
                port_reg[i] <= '0;
            end
        end
        else
        begin
            open_reg      <= open_next;
            addr_reg      <= addr_next;
            port_reg      <= port_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EPH_MIN: eph_min_reg <= cfg_data;
                    CFG_EPH_MAX: eph_max_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // Payload registers: request copy, candidate counter, response word
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd.load_req)
        begin
            req_reg   <= req;
            cand_reg  <= {1'b0, eph_min_reg};
            tries_reg <= '0;
        end
        else if (cmd.step)
        begin
            cand_reg  <= cand_reg + 17'd1;
            tries_reg <= tries_reg + TRY_W'(1);
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: src/upbt_ctrl.sv
// ----------------------------------------------------------------------------
// upbt_ctrl: controller of the UDP port binding table
// Sequences request capture, the operations that need no search and the
// ephemeral port search, and commits only when the response slot is free.
// ----------------------------------------------------------------------------
module upbt_ctrl
    import upbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.need_search)
                begin
                    state_next = ST_SEARCH;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if ((stat.search_hit || stat.search_end) && stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !stat.need_search && stat.out_free;
            end
            ST_SEARCH:
            begin
                if (stat.search_hit || stat.search_end)
                begin
                    cmd.commit = stat.out_free;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Response register is never overwritten while still held
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit while response slot occupied");

    // Candidate advances only when the search is still undecided
    a_step_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !(stat.search_hit || stat.search_end))
        else $error("search stepped past a decision");

    // Search state only for a port-less source select
    a_search_need: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> stat.need_search)
        else $error("search state without a pending port search");

    // Request capture is always followed by the execute state
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == ST_EXEC)
        else $error("request capture did not start execution");
`endif

endmodule
